FILE: rtl/kmc_pkg.sv
// Shared types and constants for the online threshold k-means cluster unit.
// No dependencies; every other file refers to it by scoped names.
package kmc_pkg;

    localparam int ELEM_BITS    = 16;
    localparam int DIST_BITS    = 36;
    localparam int COUNT_BITS   = 16;
    localparam int LABEL_BITS   = 4;
    localparam int MAXC_BITS    = 5;
    localparam int CFG_IDX_BITS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CLUSTERS = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_DIST   = 8'd1;

    localparam logic [MAXC_BITS-1:0]  MAXC_RESET  = 5'd10;
    localparam logic [DIST_BITS-1:0]  MERGE_RESET = 36'd67108864;
    localparam logic [DIST_BITS-1:0]  DIST_MAX    = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

    // input item modes
    localparam logic MODE_ELEM  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic signed [ELEM_BITS-1:0] element;
        logic                        last;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic                  created;
        logic [DIST_BITS-1:0]  nearest_distance_sq;
        logic [COUNT_BITS-1:0] member_count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_UPD_RD,
        S_UPD_GO,
        S_UPD_DIV,
        S_UPD_WR,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic elem_wr;
        logic clear;
        logic rd;
        logic scan;
        logic tag_first;
        logic tag_elast;
        logic tag_final;
        logic use_label;
        logic decide;
        logic div_start;
        logic cent_we;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic total_zero;
        logic scan_done;
        logic div_done;
        logic created;
        logic out_busy;
    } t_status;

endpackage

FILE: rtl/kmc_datapath.sv
// Datapath: sample buffer, centroid memory, distance pipeline, divider, result register.
// Depends on kmc_pkg; driven by kmc_ctrl through t_cmd.
module kmc_datapath #(
    parameter int EMB_DIM      = 32,
    parameter int MAX_CLUSTERS = 16,
    localparam int EW = $clog2(EMB_DIM),
    localparam int CW = $clog2(MAX_CLUSTERS + 1),
    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  kmc_pkg::t_cmd                           i_cmd,
    input  logic [IW-1:0]                           i_cidx,
    input  logic [EW-1:0]                           i_eidx,
    input  logic signed [kmc_pkg::ELEM_BITS-1:0]    i_element,
    input  logic                                    i_cfg_valid,
    input  logic [kmc_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [kmc_pkg::DIST_BITS-1:0]           i_cfg_data,
    input  logic                                    i_out_ready,
    output kmc_pkg::t_status                        o_status,
    output logic [CW-1:0]                           o_total,
    output logic                                    o_out_valid,
    output kmc_pkg::t_out_item                      o_out
);

    localparam int EB    = kmc_pkg::ELEM_BITS;
    localparam int CB    = kmc_pkg::COUNT_BITS;
    localparam int XW    = $clog2(EMB_DIM + 1);
    localparam int DEPTH = MAX_CLUSTERS * EMB_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = EB + 1;
    localparam int SQW   = 2 * DW;
    localparam int ACCW  = SQW + $clog2(EMB_DIM);
    localparam int CMPW  = (ACCW > kmc_pkg::DIST_BITS) ? ACCW : kmc_pkg::DIST_BITS;
    localparam int QW    = DW;
    localparam int NW    = $clog2(QW + 1);

    // configuration registers
    logic [kmc_pkg::MAXC_BITS-1:0] r_clust_limit;
    logic [kmc_pkg::DIST_BITS-1:0] r_merge_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clust_limit <= kmc_pkg::MAXC_RESET;
            r_merge_thr   <= kmc_pkg::MERGE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == kmc_pkg::REG_MAX_CLUSTERS) begin
                r_clust_limit <= i_cfg_data[kmc_pkg::MAXC_BITS-1:0];
            end else if (i_cfg_index == kmc_pkg::REG_MERGE_DIST) begin
                r_merge_thr <= i_cfg_data;
            end
        end
    end

    // sample buffer: memory plus per-element valid bits (invalid reads as zero)
    logic signed [EB-1:0] r_samp_mem [EMB_DIM];
    logic [EMB_DIM-1:0]   r_samp_vld;
    logic [XW-1:0]        r_elem_idx;
    logic signed [EB-1:0] r_samp_q;
    logic                 r_samp_qv;
    logic                 samp_wr;

    assign samp_wr = i_cmd.elem_wr && (r_elem_idx < XW'(EMB_DIM));

    always_ff @(posedge i_clk) begin
        if (samp_wr) begin
            r_samp_mem[r_elem_idx[EW-1:0]] <= i_element;
        end
        if (i_cmd.rd) begin
            r_samp_q <= r_samp_mem[i_eidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samp_vld <= '0;
            r_elem_idx <= '0;
            r_samp_qv  <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_samp_qv <= r_samp_vld[i_eidx];
            end
            if (i_cmd.finish) begin
                r_samp_vld <= '0;
                r_elem_idx <= '0;
            end else if (samp_wr) begin
                r_samp_vld[r_elem_idx[EW-1:0]] <= 1'b1;
                r_elem_idx <= r_elem_idx + XW'(1);
            end
        end
    end

    // centroid memory, one read and one write port
    logic signed [EB-1:0] r_cent_mem [DEPTH];
    logic signed [EB-1:0] r_cent_q;
    logic [IW-1:0]        r_label;
    logic [IW-1:0]        mem_cidx;
    logic [AW-1:0]        mem_addr;
    logic signed [EB-1:0] cent_wdata;

    assign mem_cidx = i_cmd.use_label ? r_label : i_cidx;
    assign mem_addr = AW'(mem_cidx) * AW'(EMB_DIM) + AW'(i_eidx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cent_we) begin
            r_cent_mem[mem_addr] <= cent_wdata;
        end
        if (i_cmd.rd) begin
            r_cent_q <= r_cent_mem[mem_addr];
        end
    end

    logic signed [EB-1:0] samp_val;
    logic signed [DW-1:0] diff;
    logic signed [SQW-1:0] prod;

    assign samp_val = r_samp_qv ? r_samp_q : '0;
    assign diff     = {samp_val[EB-1], samp_val} - {r_cent_q[EB-1], r_cent_q};
    assign prod     = diff * diff;

    // distance pipeline: read -> square -> accumulate -> compare
    logic            r_s1_vld, r_s2_vld, r_s3_vld, r_scan_done;
    logic            r_s1_first, r_s1_elast, r_s1_final;
    logic            r_s2_first, r_s2_elast, r_s2_final;
    logic            r_s3_final;
    logic [IW-1:0]   r_s1_cidx, r_s2_cidx, r_s3_cidx;
    logic [SQW-1:0]  r_sq;
    logic [ACCW-1:0] r_acc;
    logic [ACCW-1:0] r_best;
    logic [IW-1:0]   r_best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_scan_done <= 1'b0;
        end else begin
            r_s1_vld    <= i_cmd.rd && i_cmd.scan;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld && r_s2_elast;
            r_scan_done <= r_s3_vld && r_s3_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.tag_first;
        r_s1_elast <= i_cmd.tag_elast;
        r_s1_final <= i_cmd.tag_final;
        r_s1_cidx  <= i_cidx;
        r_s2_first <= r_s1_first;
        r_s2_elast <= r_s1_elast;
        r_s2_final <= r_s1_final;
        r_s2_cidx  <= r_s1_cidx;
        r_s3_final <= r_s2_final;
        r_s3_cidx  <= r_s2_cidx;
        r_sq       <= SQW'(unsigned'(prod));
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? ACCW'(r_sq) : r_acc + ACCW'(r_sq);
        end
        // lowest index wins a tie
        if (r_s3_vld && ((r_s3_cidx == '0) || (r_acc < r_best))) begin
            r_best     <= r_acc;
            r_best_idx <= r_s3_cidx;
        end
    end

    // assignment decision
    logic [CW-1:0]   r_total;
    logic            r_created;
    logic [CB-1:0]   r_count;
    logic [kmc_pkg::DIST_BITS-1:0] r_dist;
    logic [CB-1:0]   r_counts [MAX_CLUSTERS];

    logic [8:0]      tot9, mc9, lim9;
    logic [CMPW-1:0] best_cmp;
    logic            created_c;
    logic [IW-1:0]   label_c;
    logic [CB-1:0]   old_cnt, new_cnt;
    logic [kmc_pkg::DIST_BITS-1:0] dist_c;

    always_comb begin
        tot9      = 9'(r_total);
        mc9       = 9'(r_clust_limit);
        lim9      = (mc9 > 9'(MAX_CLUSTERS)) ? 9'(MAX_CLUSTERS) : mc9;
        best_cmp  = CMPW'(r_best);
        created_c = (r_total == '0) ||
                    ((best_cmp > CMPW'(r_merge_thr)) && (tot9 < lim9));
        label_c   = created_c ? r_total[IW-1:0] : r_best_idx;
        old_cnt   = created_c ? CB'(1) : r_counts[label_c];
        new_cnt   = (old_cnt < kmc_pkg::COUNT_MAX) ? old_cnt + CB'(1) : old_cnt;
        if (r_total == '0) begin
            dist_c = '0;
        end else if (best_cmp > CMPW'(kmc_pkg::DIST_MAX)) begin
            dist_c = kmc_pkg::DIST_MAX;
        end else begin
            dist_c = best_cmp[kmc_pkg::DIST_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_created         <= created_c;
            r_label           <= label_c;
            r_count           <= new_cnt;
            r_dist            <= dist_c;
            r_counts[label_c] <= new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.clear) begin
            r_total <= '0;
        end else if (i_cmd.decide && created_c) begin
            r_total <= r_total + CW'(1);
        end
    end

    // restoring divider, one quotient bit per cycle: |diff| / count
    logic [QW-1:0]   r_dv_num;
    logic [CB-1:0]   r_dv_rem;
    logic [NW-1:0]   r_dv_step;
    logic            r_dv_neg;
    logic            r_dv_busy;
    logic            r_dv_done;
    logic [DW-1:0]   mag;
    logic [CB:0]     trial;
    logic            fits;

    assign mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign trial = {r_dv_rem, r_dv_num[QW-1]};
    assign fits  = trial >= {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_num <= mag;
            r_dv_rem <= '0;
            r_dv_neg <= diff[DW-1];
        end else if (r_dv_busy) begin
            r_dv_rem <= fits ? CB'(trial - {1'b0, r_count}) : trial[CB-1:0];
            r_dv_num <= {r_dv_num[QW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
            r_dv_step <= '0;
        end else begin
            r_dv_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_dv_busy <= 1'b1;
                r_dv_step <= NW'(QW);
            end else if (r_dv_busy) begin
                r_dv_step <= r_dv_step - NW'(1);
                if (r_dv_step == NW'(1)) begin
                    r_dv_busy <= 1'b0;
                    r_dv_done <= 1'b1;
                end
            end
        end
    end

    // centroid update value: new cluster takes the sample, else moves by the quotient
    logic signed [DW:0] q_ext, q_sgn, upd;

    assign q_ext      = {1'b0, r_dv_num};
    assign q_sgn      = r_dv_neg ? -q_ext : q_ext;
    assign upd        = {{2{r_cent_q[EB-1]}}, r_cent_q} + q_sgn;
    assign cent_wdata = r_created ? samp_val : upd[EB-1:0];

    // result register, loaded when an item finishes; frees the decision registers
    logic               r_out_valid;
    kmc_pkg::t_out_item r_out;
    logic [IW+3:0]      lab_ext;

    assign lab_ext = (IW + 4)'(r_label);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.label               <= lab_ext[3:0];
            r_out.created             <= r_created;
            r_out.nearest_distance_sq <= r_dist;
            r_out.member_count        <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_total             = r_total;
    assign o_status.total_zero = (r_total == '0);
    assign o_status.scan_done  = r_scan_done;
    assign o_status.div_done   = r_dv_done;
    assign o_status.created    = r_created;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

endmodule

FILE: rtl/kmc_ctrl.sv
// Controller state machine: element intake, distance scan, decision, centroid update.
// Depends on kmc_pkg; commands kmc_datapath through t_cmd, reads t_status.
module kmc_ctrl #(
    parameter int EMB_DIM      = 32,
    parameter int MAX_CLUSTERS = 16,
    localparam int EW = $clog2(EMB_DIM),
    localparam int CW = $clog2(MAX_CLUSTERS + 1),
    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  kmc_pkg::t_status i_status,
    input  logic [CW-1:0]    i_total,
    output kmc_pkg::t_cmd    o_cmd,
    output logic [IW-1:0]    o_cidx,
    output logic [EW-1:0]    o_eidx
);

    kmc_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_cidx;
    logic [EW-1:0]   r_eidx;
    logic            accept, elast, final_elem;

    assign elast      = (r_eidx == EW'(EMB_DIM - 1));
    assign final_elem = elast && ((CW'(r_cidx) + CW'(1)) == i_total);
    assign accept     = i_in_valid && o_in_ready;

    // items are taken only between embeddings
    assign o_in_ready = (r_state == kmc_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmc_pkg::S_IDLE: begin
                if (accept && (i_in_mode == kmc_pkg::MODE_ELEM) && i_in_last) begin
                    n_state = i_status.total_zero ? kmc_pkg::S_DECIDE : kmc_pkg::S_SCAN;
                end
            end
            kmc_pkg::S_SCAN: begin
                if (final_elem) n_state = kmc_pkg::S_DRAIN;
            end
            kmc_pkg::S_DRAIN: begin
                if (i_status.scan_done) n_state = kmc_pkg::S_DECIDE;
            end
            kmc_pkg::S_DECIDE: n_state = kmc_pkg::S_UPD_RD;
            kmc_pkg::S_UPD_RD: n_state = kmc_pkg::S_UPD_GO;
            kmc_pkg::S_UPD_GO: begin
                if (i_status.created) begin
                    n_state = elast ? kmc_pkg::S_FINISH : kmc_pkg::S_UPD_RD;
                end else begin
                    n_state = kmc_pkg::S_UPD_DIV;
                end
            end
            kmc_pkg::S_UPD_DIV: begin
                if (i_status.div_done) n_state = kmc_pkg::S_UPD_WR;
            end
            kmc_pkg::S_UPD_WR: n_state = elast ? kmc_pkg::S_FINISH : kmc_pkg::S_UPD_RD;
            // hold while the previous result is still waiting
            kmc_pkg::S_FINISH: begin
                if (!i_status.out_busy) n_state = kmc_pkg::S_IDLE;
            end
            default: n_state = kmc_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            kmc_pkg::S_IDLE: begin
                o_cmd.elem_wr = accept && (i_in_mode == kmc_pkg::MODE_ELEM);
                o_cmd.clear   = accept && (i_in_mode == kmc_pkg::MODE_CLEAR);
            end
            kmc_pkg::S_SCAN: begin
                o_cmd.rd        = 1'b1;
                o_cmd.scan      = 1'b1;
                o_cmd.tag_first = (r_eidx == '0);
                o_cmd.tag_elast = elast;
                o_cmd.tag_final = final_elem;
            end
            kmc_pkg::S_DECIDE: o_cmd.decide = 1'b1;
            kmc_pkg::S_UPD_RD: begin
                o_cmd.rd        = 1'b1;
                o_cmd.use_label = 1'b1;
            end
            kmc_pkg::S_UPD_GO: begin
                o_cmd.use_label = 1'b1;
                o_cmd.cent_we   = i_status.created;
                o_cmd.div_start = !i_status.created;
            end
            kmc_pkg::S_UPD_WR: begin
                o_cmd.use_label = 1'b1;
                o_cmd.cent_we   = 1'b1;
            end
            kmc_pkg::S_FINISH: o_cmd.finish = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

    // state and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmc_pkg::S_IDLE;
            r_cidx  <= '0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == kmc_pkg::S_IDLE) begin
                r_cidx <= '0;
                r_eidx <= '0;
            end else if (r_state == kmc_pkg::S_SCAN) begin
                if (elast) begin
                    r_eidx <= '0;
                    r_cidx <= r_cidx + IW'(1);
                end else begin
                    r_eidx <= r_eidx + EW'(1);
                end
            end else if ((r_state == kmc_pkg::S_UPD_WR) ||
                         ((r_state == kmc_pkg::S_UPD_GO) && i_status.created)) begin
                r_eidx <= elast ? '0 : r_eidx + EW'(1);
            end
        end
    end

    assign o_cidx = r_cidx;
    assign o_eidx = r_eidx;

endmodule

FILE: rtl/online_threshold_kmeans_cluster_unit.sv
// Non-last element and clear items are taken without leaving the idle state. A last item runs a
// distance scan over K open clusters (one centroid element read per cycle), pipeline drain and
// decide, then an update per element that opens a new cluster or moves an existing centroid via the
// 17-step serial divider, and finish. Finish waits while the previous result is still held.
// Synchronous active-low reset empties the cluster table and sample buffer; centroid and count
// stores are not cleared.
module online_threshold_kmeans_cluster_unit #(
    parameter int EMB_DIM      = 32,
    parameter int MAX_CLUSTERS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  kmc_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output kmc_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kmc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [kmc_pkg::DIST_BITS-1:0]       i_cfg_data
);

    localparam int EW = $clog2(EMB_DIM);
    localparam int CW = $clog2(MAX_CLUSTERS + 1);
    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    kmc_pkg::t_cmd    cmd;
    kmc_pkg::t_status status;
    logic [CW-1:0]    total;
    logic [IW-1:0]    cidx;
    logic [EW-1:0]    eidx;

    // registers are written whenever offered
    assign o_cfg_ready = 1'b1;

    kmc_ctrl #(
        .EMB_DIM      (EMB_DIM),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in.mode),
        .i_in_last  (i_in.last),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .i_total    (total),
        .o_cmd      (cmd),
        .o_cidx     (cidx),
        .o_eidx     (eidx)
    );

    kmc_datapath #(
        .EMB_DIM      (EMB_DIM),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cidx      (cidx),
        .i_eidx      (eidx),
        .i_element   (i_in.element),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_total     (total),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/kmc_checker.sv
// Port-level checks for online_threshold_kmeans_cluster_unit, attached by bind.
// Depends on kmc_pkg.
module kmc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input kmc_pkg::t_in_item                i_in,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input kmc_pkg::t_out_item               o_out
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a fresh cluster always reports count two
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.created |-> o_out.member_count == 16'd2)
        else $error("new cluster count not two");

    // any assigned cluster has at least two members after update
    a_min_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.member_count != 16'd0 && o_out.member_count != 16'd1)
        else $error("member count below two");

    // the block is busy in the cycle after it takes a last element
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.mode == kmc_pkg::MODE_ELEM && i_in.last
        |=> !o_in_ready)
        else $error("ready right after last element");

endmodule

bind online_threshold_kmeans_cluster_unit kmc_checker u_kmc_checker (.*);
